### sv/mqlf_pkg.sv
// ----------------------------------------------------------------------------
// mqlf_pkg
// Shared sizes, codes and types of the multi-queue linked fifo.
// ----------------------------------------------------------------------------
package mqlf_pkg;

  localparam int NUM_QUEUES = 8;
  localparam int POOL_DEPTH = 256;
  localparam int DATA_WIDTH = 64;

  // port widths
  localparam int IO_DATA_W = 64;
  localparam int QID_W     = 3;
  localparam int ACTQ_W    = 4;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  localparam int PTR_W = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CNT_W = PTR_W + 1;
  localparam int QSEL_W = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;

  // register map
  localparam logic REG_ACTIVE_QUEUES = 1'b0;
  localparam logic [ACTQ_W-1:0] ACTIVE_QUEUES_RST = ACTQ_W'(8);

  // input command field
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // classified operations
  localparam logic [1:0] OP_ENQ  = 2'd0;
  localparam logic [1:0] OP_DEQ  = 2'd1;
  localparam logic [1:0] OP_BADQ = 2'd2;

  // result status
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;
  localparam logic [1:0] ST_BADQ  = 2'd3;

  typedef struct packed {
    logic [1:0]            op;
    logic [QSEL_W-1:0]     qid;
    logic [DATA_WIDTH-1:0] data;
  } cmd_t;

  // front to back hand-off
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } back_req_t;

endpackage

### sv/mqlf_front.sv
// ----------------------------------------------------------------------------
// mqlf_front
// Accepts input transactions, checks the queue number and holds classified
// commands in a two-entry queue for the execution engine.
// ----------------------------------------------------------------------------
module mqlf_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic [mqlf_pkg::QID_W-1:0]          in_queue_id,
  input  logic [mqlf_pkg::IO_DATA_W-1:0]      in_data_in,
  input  logic [mqlf_pkg::ACTQ_W-1:0]         active_queues,
  output mqlf_pkg::back_req_t                 req,
  input  logic                                pop
);

  mqlf_pkg::cmd_t   slot_r [2];
  logic             wr_ptr_r, wr_ptr_nxt;
  logic             rd_ptr_r, rd_ptr_nxt;
  logic [1:0]       count_r, count_nxt;
  mqlf_pkg::cmd_t   cmd_in;
  logic             push;
  logic             q_ok;

  // queue number must be below both the active count and the build size
  assign q_ok = (mqlf_pkg::ACTQ_W'(in_queue_id) < active_queues) &&
                (7'(in_queue_id) < 7'(mqlf_pkg::NUM_QUEUES));

  always_comb begin
    cmd_in.qid  = mqlf_pkg::QSEL_W'(in_queue_id);
    cmd_in.data = in_data_in[mqlf_pkg::DATA_WIDTH-1:0];
    if (!q_ok) begin
      cmd_in.op = mqlf_pkg::OP_BADQ;
    end else if (in_command == mqlf_pkg::CMD_DEQ) begin
      cmd_in.op = mqlf_pkg::OP_DEQ;
    end else begin
      cmd_in.op = mqlf_pkg::OP_ENQ;
    end
  end

  assign in_ready  = (count_r != 2'd2);
  assign push      = in_valid && in_ready;
  assign req.valid = (count_r != 2'd0);
  assign req.cmd   = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= cmd_in;
    end
  end

endmodule

### sv/mqlf_back.sv
// ----------------------------------------------------------------------------
// mqlf_back
// Execution engine: queue pointers, free list, link and data memories and the
// result register.
// ----------------------------------------------------------------------------
module mqlf_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  mqlf_pkg::back_req_t              req,
  output logic                             pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [mqlf_pkg::IO_DATA_W-1:0]   out_data_out,
  output logic [1:0]                       out_status
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_FIN  = 1'b1;

  localparam int NQ = mqlf_pkg::NUM_QUEUES;
  localparam int PW = mqlf_pkg::PTR_W;
  localparam int CW = mqlf_pkg::CNT_W;
  localparam int DW = mqlf_pkg::DATA_WIDTH;
  localparam logic [CW-1:0] POOL_CNT = CW'(mqlf_pkg::POOL_DEPTH);

  // shared pool
  logic [PW-1:0] link_mem [mqlf_pkg::POOL_DEPTH];
  logic [DW-1:0] data_mem [mqlf_pkg::POOL_DEPTH];

  logic [PW-1:0] head_r [NQ];
  logic [PW-1:0] head_nxt [NQ];
  logic [PW-1:0] tail_r [NQ];
  logic [PW-1:0] tail_nxt [NQ];
  logic [NQ-1:0] nonempty_r, nonempty_nxt;

  logic [PW-1:0] rec_head_r, rec_head_nxt;
  logic [CW-1:0] rec_cnt_r, rec_cnt_nxt;
  logic [CW-1:0] fresh_cnt_r, fresh_cnt_nxt;

  logic                      state_r, state_nxt;
  logic                      cur_deq_r, cur_deq_nxt;
  logic [mqlf_pkg::QSEL_W-1:0] cur_q_r, cur_q_nxt;
  logic [PW-1:0]             cur_e_r, cur_e_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [DW-1:0] out_data_r, out_data_nxt;
  logic [1:0]    out_status_r, out_status_nxt;

  logic          link_we, link_re;
  logic [PW-1:0] link_waddr, link_wdata, link_raddr, link_rd_r;
  logic          data_we, data_re;
  logic [PW-1:0] data_waddr, data_raddr;
  logic [DW-1:0] data_wdata, data_rd_r;

  logic          out_free;
  logic [PW-1:0] alloc_e;
  logic          q_ne;

  assign out_free = !out_valid_r || out_ready;
  assign q_ne     = nonempty_r[req.cmd.qid];
  assign alloc_e  = (rec_cnt_r != '0) ? rec_head_r : fresh_cnt_r[PW-1:0];

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    nonempty_nxt   = nonempty_r;
    rec_head_nxt   = rec_head_r;
    rec_cnt_nxt    = rec_cnt_r;
    fresh_cnt_nxt  = fresh_cnt_r;
    state_nxt      = state_r;
    cur_deq_nxt    = cur_deq_r;
    cur_q_nxt      = cur_q_r;
    cur_e_nxt      = cur_e_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    pop            = 1'b0;
    link_we        = 1'b0;
    link_waddr     = '0;
    link_wdata     = '0;
    link_re        = 1'b0;
    link_raddr     = '0;
    data_we        = 1'b0;
    data_waddr     = '0;
    data_wdata     = req.cmd.data;
    data_re        = 1'b0;
    data_raddr     = '0;

    case (state_r)
      S_IDLE: begin
        if (req.valid && out_free) begin
          pop          = 1'b1;
          out_data_nxt = '0;
          case (req.cmd.op)
            mqlf_pkg::OP_ENQ: begin
              out_valid_nxt = 1'b1;
              if ((fresh_cnt_r == POOL_CNT) && (rec_cnt_r == '0)) begin
                out_status_nxt = mqlf_pkg::ST_FULL;
              end else begin
                out_status_nxt = mqlf_pkg::ST_OK;
                data_we        = 1'b1;
                data_waddr     = alloc_e;
                if (q_ne) begin
                  // append behind the current tail
                  link_we    = 1'b1;
                  link_waddr = tail_r[req.cmd.qid];
                  link_wdata = alloc_e;
                end else begin
                  head_nxt[req.cmd.qid] = alloc_e;
                end
                tail_nxt[req.cmd.qid]     = alloc_e;
                nonempty_nxt[req.cmd.qid] = 1'b1;
                if (rec_cnt_r != '0) begin
                  // recycled entry: fetch its successor to advance the list
                  rec_cnt_nxt = rec_cnt_r - CW'(1);
                  link_re     = 1'b1;
                  link_raddr  = rec_head_r;
                  cur_deq_nxt = 1'b0;
                  state_nxt   = S_FIN;
                end else begin
                  fresh_cnt_nxt = fresh_cnt_r + CW'(1);
                end
              end
            end
            mqlf_pkg::OP_DEQ: begin
              if (!q_ne) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = mqlf_pkg::ST_EMPTY;
              end else begin
                link_re     = 1'b1;
                link_raddr  = head_r[req.cmd.qid];
                data_re     = 1'b1;
                data_raddr  = head_r[req.cmd.qid];
                cur_deq_nxt = 1'b1;
                cur_q_nxt   = req.cmd.qid;
                cur_e_nxt   = head_r[req.cmd.qid];
                state_nxt   = S_FIN;
              end
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = mqlf_pkg::ST_BADQ;
            end
          endcase
        end
      end
      S_FIN: begin
        if (!cur_deq_r) begin
          rec_head_nxt = link_rd_r;
          state_nxt    = S_IDLE;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = mqlf_pkg::ST_OK;
          out_data_nxt   = data_rd_r;
          if (cur_e_r == tail_r[cur_q_r]) begin
            nonempty_nxt[cur_q_r] = 1'b0;
          end else begin
            head_nxt[cur_q_r] = link_rd_r;
          end
          // give the entry back to the free list
          link_we      = 1'b1;
          link_waddr   = cur_e_r;
          link_wdata   = rec_head_r;
          rec_head_nxt = cur_e_r;
          rec_cnt_nxt  = rec_cnt_r + CW'(1);
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nonempty_r  <= '0;
      rec_head_r  <= '0;
      rec_cnt_r   <= '0;
      fresh_cnt_r <= '0;
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      nonempty_r  <= nonempty_nxt;
      rec_head_r  <= rec_head_nxt;
      rec_cnt_r   <= rec_cnt_nxt;
      fresh_cnt_r <= fresh_cnt_nxt;
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r       <= head_nxt;
    tail_r       <= tail_nxt;
    cur_deq_r    <= cur_deq_nxt;
    cur_q_r      <= cur_q_nxt;
    cur_e_r      <= cur_e_nxt;
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    if (link_re) begin
      link_rd_r <= link_mem[link_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (data_we) begin
      data_mem[data_waddr] <= data_wdata;
    end
    if (data_re) begin
      data_rd_r <= data_mem[data_raddr];
    end
  end

  assign out_valid    = out_valid_r;
  assign out_data_out = mqlf_pkg::IO_DATA_W'(out_data_r);
  assign out_status   = out_status_r;

endmodule

### sv/multi_queue_linked_fifo.sv
// ----------------------------------------------------------------------------
// multi_queue_linked_fifo
// Several fifo queues kept as linked lists in one shared entry pool.
// ----------------------------------------------------------------------------
// usage:
//   in_*  : one transaction per command, enqueue in_data_in on in_queue_id or
//           dequeue from it; valid/ready handshake
//   out_* : exactly one result transaction per command, in command order,
//           with the dequeued word and a status code
//   apb   : register 0 (active_queues) at byte address 0, written while idle
// flow: a command reaches the engine in the cycle after it is taken; bad
//   queue numbers, empty/full rejects and all enqueues have their result
//   registered from the idle state, dequeues from S_FIN after the link and
//   data memory read. throughput: one command every cycle while the result
//   register is free for the idle-state cases; dequeues and enqueues that
//   reuse a freed entry hold the engine in S_FIN for the link memory read.
// reset: all queues empty, pool fully free, active_queues = 8; no clearing
//   pass, untouched entries are handed out by a fill counter
// stall: a two-entry command queue keeps taking transactions while a result
//   waits in the output register; with both full, in_ready drops
// ----------------------------------------------------------------------------
module multi_queue_linked_fifo (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_command,
  input  logic [mqlf_pkg::QID_W-1:0]          in_queue_id,
  input  logic [mqlf_pkg::IO_DATA_W-1:0]      in_data_in,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mqlf_pkg::IO_DATA_W-1:0]      out_data_out,
  output logic [1:0]                          out_status,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [mqlf_pkg::PADDR_W-1:0]        paddr,
  input  logic [mqlf_pkg::PDATA_W-1:0]        pwdata,
  output logic [mqlf_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready
);

  logic [mqlf_pkg::ACTQ_W-1:0] active_queues_r, active_queues_nxt;
  logic                        reg_sel;
  mqlf_pkg::back_req_t         req;
  logic                        pop;

  // register index sits above the two byte-offset bits
  assign reg_sel = (paddr[2] == mqlf_pkg::REG_ACTIVE_QUEUES);
  assign pready  = 1'b1;

  always_comb begin
    active_queues_nxt = active_queues_r;
    if (psel && penable && pwrite && pready && reg_sel) begin
      active_queues_nxt = pwdata[mqlf_pkg::ACTQ_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_queues_r <= mqlf_pkg::ACTIVE_QUEUES_RST;
    end else begin
      active_queues_r <= active_queues_nxt;
    end
  end

  // read back
  assign prdata = reg_sel ? mqlf_pkg::PDATA_W'(active_queues_r) : '0;

  // front: accept, check queue number, buffer
  mqlf_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_command    (in_command),
    .in_queue_id   (in_queue_id),
    .in_data_in    (in_data_in),
    .active_queues (active_queues_r),
    .req           (req),
    .pop           (pop)
  );

  // back: pointer updates, free list, pool memories, result register
  mqlf_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .req          (req),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data_out (out_data_out),
    .out_status   (out_status)
  );

endmodule
